// ===== sv/des_ks_pkg.sv =====
`timescale 1ns / 1ps
// des_ks_pkg: shared types, tables and permutation functions for the DES key schedule
// no dependencies

package des_ks_pkg;

  localparam int unsigned ROUNDS_DEF = 16;
  localparam int unsigned KEY_W      = 64;
  localparam int unsigned HALF_W     = 28;
  localparam int unsigned SUBKEY_W   = 48;
  localparam int unsigned ROUND_W    = 4;

  // bit r set: round r rotates by two places, else by one
  localparam logic [15:0] SHIFT_TWO = 16'h7EFC;

  localparam logic [7:0] PC1_TAB [56] = '{
    8'd57, 8'd49, 8'd41, 8'd33, 8'd25, 8'd17, 8'd9,  8'd1,  8'd58, 8'd50, 8'd42, 8'd34,
    8'd26, 8'd18, 8'd10, 8'd2,  8'd59, 8'd51, 8'd43, 8'd35, 8'd27, 8'd19, 8'd11, 8'd3,
    8'd60, 8'd52, 8'd44, 8'd36, 8'd63, 8'd55, 8'd47, 8'd39, 8'd31, 8'd23, 8'd15, 8'd7,
    8'd62, 8'd54, 8'd46, 8'd38, 8'd30, 8'd22, 8'd14, 8'd6,  8'd61, 8'd53, 8'd45, 8'd37,
    8'd29, 8'd21, 8'd13, 8'd5,  8'd28, 8'd20, 8'd12, 8'd4
  };

  localparam logic [7:0] PC2_TAB [48] = '{
    8'd14, 8'd17, 8'd11, 8'd24, 8'd1,  8'd5,  8'd3,  8'd28, 8'd15, 8'd6,  8'd21, 8'd10,
    8'd23, 8'd19, 8'd12, 8'd4,  8'd26, 8'd8,  8'd16, 8'd7,  8'd27, 8'd20, 8'd13, 8'd2,
    8'd41, 8'd52, 8'd31, 8'd37, 8'd47, 8'd55, 8'd30, 8'd40, 8'd51, 8'd45, 8'd33, 8'd48,
    8'd44, 8'd49, 8'd39, 8'd56, 8'd34, 8'd53, 8'd46, 8'd42, 8'd50, 8'd36, 8'd29, 8'd32
  };

  // token carried from cell to cell: one key's halves
  typedef struct packed {
    logic              valid;
    logic [HALF_W-1:0] c;
    logic [HALF_W-1:0] d;
  } cell_t;

  // key permutation, parity bits dropped; returns {c, d}
  function automatic logic [2*HALF_W-1:0] pc1(input logic [KEY_W-1:0] key);
    logic [HALF_W-1:0] c;
    logic [HALF_W-1:0] d;
    for (int i = 0; i < HALF_W; i++) begin
      c[HALF_W-1-i] = key[KEY_W - int'(PC1_TAB[i])];
      d[HALF_W-1-i] = key[KEY_W - int'(PC1_TAB[i+HALF_W])];
    end
    return {c, d};
  endfunction

  // compression permutation over c:d
  function automatic logic [SUBKEY_W-1:0] pc2(input logic [HALF_W-1:0] c,
                                              input logic [HALF_W-1:0] d);
    logic [2*HALF_W-1:0] cd;
    logic [SUBKEY_W-1:0] sk;
    cd = {c, d};
    for (int i = 0; i < SUBKEY_W; i++) begin
      sk[SUBKEY_W-1-i] = cd[2*HALF_W - int'(PC2_TAB[i])];
    end
    return sk;
  endfunction

  // rotate one half left by the amount scheduled for the given round
  function automatic logic [HALF_W-1:0] rotl_round(input logic [HALF_W-1:0] v,
                                                   input int unsigned rnd);
    if (SHIFT_TWO[rnd[3:0]]) begin
      return {v[HALF_W-3:0], v[HALF_W-1:HALF_W-2]};
    end else begin
      return {v[HALF_W-2:0], v[HALF_W-1]};
    end
  endfunction

endpackage

// ===== sv/des_ks_cell.sv =====
`timescale 1ns / 1ps
// des_ks_cell: one round cell of the key schedule chain
// depends on des_ks_pkg (cell_t, rotl_round, pc2)

module des_ks_cell #(
  parameter int unsigned INDEX = 0
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              advance,
  input  des_ks_pkg::cell_t                 tok_in,
  output des_ks_pkg::cell_t                 tok,
  output logic [des_ks_pkg::SUBKEY_W-1:0]   subkey
);

  // halves are rotated for this round as they enter the cell register
  always_ff @(posedge clk) begin
    if (rst) begin
      tok.valid <= 1'b0;
    end else if (advance) begin
      tok.valid <= tok_in.valid;
    end
    if (advance) begin
      tok.c <= des_ks_pkg::rotl_round(tok_in.c, INDEX);
      tok.d <= des_ks_pkg::rotl_round(tok_in.d, INDEX);
    end
  end

  // masked so the top level can or the cells together
  assign subkey = des_ks_pkg::pc2(tok.c, tok.d) & {des_ks_pkg::SUBKEY_W{tok.valid}};

endmodule

// ===== sv/des_key_schedule_top.sv =====
`timescale 1ns / 1ps
// des_key_schedule_top: DES key schedule, chain of round cells and output register
// depends on des_ks_pkg and des_ks_cell

// usage
//   input channel: in_valid / in_ready carry one 64-bit key per request
//   output channel: out_valid / out_ready carry one subkey per request, with
//   its round index and a last flag on the final round of the key
//   a key runs down a row of ROUNDS cells (ROUNDS held to 1 .. 16); each cell
//   rotates the halves for its round, and the cell holding the key feeds the
//   compression permutation into the output register, one subkey per cycle
//   unless stalled; a key fills cell 0, then its subkey fills the output register
//   throughput: one subkey per cycle unless stalled; the chain holds one key,
//   and the next is taken in the cycle that the last cell hands its subkey to
//   the output register
//   stall: when out_ready is low with a subkey waiting, the whole chain holds
//   and in_ready stays low until the chain moves again
//   reset: rst (synchronous) empties the chain and the output register; no
//   clearing pass is needed

module des_key_schedule_top #(
  parameter int unsigned ROUNDS = des_ks_pkg::ROUNDS_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [des_ks_pkg::KEY_W-1:0]      key,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [des_ks_pkg::SUBKEY_W-1:0]   subkey,
  output logic [des_ks_pkg::ROUND_W-1:0]    round,
  output logic                              last
);

  localparam int unsigned HW = des_ks_pkg::HALF_W;
  // round count held to the range the schedule defines
  localparam int unsigned NR = (ROUNDS < 1) ? 1 : ((ROUNDS > 16) ? 16 : ROUNDS);

  des_ks_pkg::cell_t                     tok  [NR];
  des_ks_pkg::cell_t                     head;
  logic [des_ks_pkg::SUBKEY_W-1:0]       sk   [NR];
  logic [NR-1:0]                         cell_valid;
  logic [2*HW-1:0]                       halves;
  logic                                  advance;
  logic                                  any_valid;
  logic [des_ks_pkg::SUBKEY_W-1:0]       sk_sel;
  logic [des_ks_pkg::ROUND_W-1:0]        round_sel;

  // chain moves whenever the output register can take a subkey
  assign advance  = !out_valid || out_ready;
  // chain empty, or its key is leaving the last cell this cycle
  assign in_ready = advance && (!any_valid || cell_valid[NR-1]);

  assign halves     = des_ks_pkg::pc1(key);
  assign head.valid = in_valid && in_ready;
  assign head.c     = halves[2*HW-1:HW];
  assign head.d     = halves[HW-1:0];

  for (genvar i = 0; i < NR; i++) begin : g_cell
    des_ks_cell #(
      .INDEX (i)
    ) u_cell (
      .clk     (clk),
      .rst     (rst),
      .advance (advance),
      .tok_in  ((i == 0) ? head : tok[(i == 0) ? 0 : i-1]),
      .tok     (tok[i]),
      .subkey  (sk[i])
    );
    assign cell_valid[i] = tok[i].valid;
  end

  // at most one cell holds a key, so an or picks its subkey and round
  always_comb begin
    sk_sel    = '0;
    round_sel = '0;
    for (int i = 0; i < NR; i++) begin
      sk_sel    = sk_sel | sk[i];
      round_sel = round_sel | (des_ks_pkg::ROUND_W'(i) & {des_ks_pkg::ROUND_W{cell_valid[i]}});
    end
  end

  assign any_valid = |cell_valid;

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= any_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      subkey <= sk_sel;
      round  <= round_sel;
      last   <= cell_valid[NR-1];
    end
  end

  // one key in the chain at a time
  a_one_token: assert property (@(posedge clk) disable iff (rst)
    $onehot0(cell_valid))
    else $error("more than one cell holds a key");

  // accepted key lands in the first cell
  a_key_enters: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> cell_valid[0])
    else $error("accepted key missing from first cell");

  // the flagged subkey belongs to the final round
  a_last_round: assert property (@(posedge clk) disable iff (rst)
    out_valid && last |-> round == des_ks_pkg::ROUND_W'(NR-1))
    else $error("last flag on wrong round");

  // a stalled output freezes the chain
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> $stable(cell_valid))
    else $error("chain moved during output stall");

endmodule

// ===== tb/tb.sv =====
`timescale 1ns / 1ps
// tb: self-checking bench for des_key_schedule_top, sixteen subkeys expected per key request
// depends on des_ks_pkg (widths) and des_key_schedule_top; the subkey predictor is local

// permuted choice 1 and 2 selections and the per-round shift, in DES bit numbering
localparam int unsigned KS_PC1_SEL [56] = '{
  57, 49, 41, 33, 25, 17, 9,  1,  58, 50, 42, 34, 26, 18,
  10, 2,  59, 51, 43, 35, 27, 19, 11, 3,  60, 52, 44, 36,
  63, 55, 47, 39, 31, 23, 15, 7,  62, 54, 46, 38, 30, 22,
  14, 6,  61, 53, 45, 37, 29, 21, 13, 5,  28, 20, 12, 4
};

localparam int unsigned KS_PC2_SEL [48] = '{
  14, 17, 11, 24, 1,  5,  3,  28, 15, 6,  21, 10,
  23, 19, 12, 4,  26, 8,  16, 7,  27, 20, 13, 2,
  41, 52, 31, 37, 47, 55, 30, 40, 51, 45, 33, 48,
  44, 49, 39, 56, 34, 53, 46, 42, 50, 36, 29, 32
};

localparam int unsigned KS_SHIFT [16] = '{1, 1, 2, 2, 2, 2, 2, 2, 1, 2, 2, 2, 2, 2, 2, 1};

localparam int unsigned KS_ROUNDS = 16;

typedef struct packed {
  logic [des_ks_pkg::SUBKEY_W-1:0] subkey;
  logic [des_ks_pkg::ROUND_W-1:0]  rnd;
  logic                            lst;
} subkey_due_t;

class subkey_board;
  subkey_due_t subkeys_due[$];
  int          mismatches;
  logic [27:0] c_half;
  logic [27:0] d_half;

  function new();
    mismatches = 0;
    c_half     = '0;
    d_half     = '0;
  endfunction

  function void flag(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("%0t ERROR %s", $realtime, msg);
  endfunction

  // accepted key: run the whole schedule and queue all sixteen subkeys
  function void expand_key(input logic [63:0] k);
    logic [55:0] cd;
    subkey_due_t e;
    for (int i = 0; i < 28; i++) begin
      c_half[27-i] = k[64 - KS_PC1_SEL[i]];
      d_half[27-i] = k[64 - KS_PC1_SEL[i+28]];
    end
    for (int r = 0; r < KS_ROUNDS; r++) begin
      if (KS_SHIFT[r] == 2) begin
        c_half = {c_half[25:0], c_half[27:26]};
        d_half = {d_half[25:0], d_half[27:26]};
      end else begin
        c_half = {c_half[26:0], c_half[27]};
        d_half = {d_half[26:0], d_half[27]};
      end
      cd = {c_half, d_half};
      for (int i = 0; i < 48; i++) e.subkey[47-i] = cd[56 - KS_PC2_SEL[i]];
      e.rnd = r[3:0];
      e.lst = (r == KS_ROUNDS - 1);
      subkeys_due.push_back(e);
    end
  endfunction

  function void check_subkey(input logic [47:0] sk, input logic [3:0] rnd, input logic lst);
    subkey_due_t e;
    if (subkeys_due.size() == 0) begin
      flag($sformatf("unexpected subkey %h round %0d last %0d", sk, rnd, lst));
      return;
    end
    e = subkeys_due.pop_front();
    if (sk !== e.subkey || rnd !== e.rnd || lst !== e.lst)
      flag($sformatf("expected subkey %h round %0d last %0d, got subkey %h round %0d last %0d",
                     e.subkey, e.rnd, e.lst, sk, rnd, lst));
  endfunction

  function int pending();
    return subkeys_due.size();
  endfunction

  // anything still queued at the end never came out
  function void close_out();
    if (subkeys_due.size() != 0)
      flag($sformatf("%0d subkeys never arrived", subkeys_due.size()));
  endfunction
endclass

module tb;

  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transfer on either channel
  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off to back up the chain
  localparam int DRAIN_CYCLES   = 20;    // margin after the last expected subkey to catch extras
  localparam int RANDOM_KEYS    = 25;    // per idling phase, four phases

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [63:0] key = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [47:0] subkey;
  logic [3:0]  round;
  logic        last;

  // idling knobs, percent per cycle
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  // set by the stimulus to ask the receiver for one long hold-off
  bit hold_armed = 1'b0;
  int hold_left  = 0;
  int quiet_cycles = 0;

  subkey_board board = new();

  always #5 clk = ~clk;

  des_key_schedule_top dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .key       (key),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .subkey    (subkey),
    .round     (round),
    .last      (last)
  );

  // result check: everything changes only at rising edges, so values seen at
  // the falling edge are the ones the next rising edge will take
  always @(negedge clk) begin
    if (!rst && out_valid && out_ready) board.check_subkey(subkey, round, last);
  end

  // receiver ready
  always @(posedge clk) begin
    if (hold_armed) begin
      hold_armed = 1'b0;
      hold_left  = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      // hold-off counted here, the sender keeps offering keys meanwhile
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // watchdog: ends the run if neither channel moves for too long
  always @(negedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("des_key_schedule_top verification failed");
        $finish;
      end
    end
  end

  // one key request; called right after a rising edge. valid is only lowered
  // when a gap is taken, so a back-to-back key never toggles it within a step
  task automatic send_key(input logic [63:0] k);
    int gap;
    bit taken;
    gap = 0;
    while (gap < 16 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    key      <= k;
    // ready seen at the falling edge holds through the next rising edge
    do begin
      @(negedge clk);
      taken = in_ready;
      @(posedge clk);
    end while (!taken);
    board.expand_key(k);
  endtask

  task automatic set_idling(input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // random key: mostly dense, some sparse, some with the parity bits cleared or set
  function automatic logic [63:0] random_key();
    logic [63:0] k;
    int pick;
    k    = {$urandom, $urandom};
    pick = $urandom_range(99);
    if (pick < 15) k = 64'd1 << $urandom_range(63);
    else if (pick < 30) k = k & 64'hFEFE_FEFE_FEFE_FEFE;
    else if (pick < 40) k = k | 64'h0101_0101_0101_0101;
    return k;
  endfunction

  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed keys, no idling
    set_idling(0, 0);
    send_key(64'h0000_0000_0000_0000);
    send_key(64'hFFFF_FFFF_FFFF_FFFF);
    // parity bits only: must give the same subkeys as the zero key
    send_key(64'h0101_0101_0101_0101);
    // every bit except the parity bits
    send_key(64'hFEFE_FEFE_FEFE_FEFE);
    send_key(64'hAAAA_AAAA_AAAA_AAAA);
    send_key(64'h5555_5555_5555_5555);
    send_key(64'h1334_5779_9BBC_DFF1);
    // same key again: schedule restarts from scratch
    send_key(64'h1334_5779_9BBC_DFF1);
    // weak keys, both halves constant
    send_key(64'h1F1F_1F1F_0E0E_0E0E);
    send_key(64'hE0E0_E0E0_F1F1_F1F1);
    send_key(64'h8000_0000_0000_0000);
    send_key(64'h0000_0000_0000_0001);
    send_key(64'h0000_0000_0000_0002);
    send_key(64'h0123_4567_89AB_CDEF);
    send_key(64'hFFFF_FFFF_0000_0000);
    send_key(64'h0000_0000_FFFF_FFFF);

    // random keys, no idling, with one long receiver hold-off so the chain
    // backs up and in_ready drops while keys are still offered
    hold_armed = 1'b1;
    for (int i = 0; i < RANDOM_KEYS; i++) send_key(random_key());

    // sender idles about half the time
    set_idling(51, 0);
    for (int i = 0; i < RANDOM_KEYS; i++) send_key(random_key());

    // receiver stalls about half the time
    set_idling(0, 51);
    for (int i = 0; i < RANDOM_KEYS; i++) send_key(random_key());

    // light idling on both sides
    set_idling(13, 13);
    for (int i = 0; i < RANDOM_KEYS; i++) send_key(random_key());

    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    // catch any subkey beyond the sixteen per key
    repeat (DRAIN_CYCLES) @(posedge clk);
    board.close_out();

    if (board.mismatches == 0) begin
      $display("des_key_schedule_top verification clean");
    end else begin
      $display("des_key_schedule_top verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
sv/des_ks_pkg.sv
sv/des_ks_cell.sv
sv/des_key_schedule_top.sv
tb/tb.sv
